### sv/utf8_byte_stream_decoder_top_macros.svh
// Assertion macros shared by the decoder's checker.
`ifndef UTF8_BYTE_STREAM_DECODER_TOP_MACROS_SVH
`define UTF8_BYTE_STREAM_DECODER_TOP_MACROS_SVH

// Same-cycle implication checked at every clock edge outside reset.
`define UTF8D_ASSERT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Implication whose consequent is checked at the next clock edge.
`define UTF8D_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### sv/utf8d_pkg.sv
// Package with the decoder's types, status codes and byte constants.
package utf8d_pkg;

    typedef enum logic [1:0] {
        ST_PENDING = 2'd0,
        ST_CHAR    = 2'd1,
        ST_END     = 2'd2,
        ST_ILLEGAL = 2'd3
    } status_t;

    typedef struct packed {
        logic       utf8_mode;
        logic [7:0] single_byte_limit;
    } cfg_t;

    localparam logic REG_UTF8_MODE         = 1'b0;
    localparam logic REG_SINGLE_BYTE_LIMIT = 1'b1;

    localparam logic       UTF8_MODE_RESET  = 1'b1;
    localparam logic [7:0] BYTE_LIMIT_RESET = 8'd127;

    localparam logic [7:0]  ASCII_END     = 8'h80;
    localparam logic [7:0]  LEAD2_MIN     = 8'hC2;
    localparam logic [7:0]  LEAD3_MIN     = 8'hE0;
    localparam logic [7:0]  LEAD_END      = 8'hF0;
    localparam logic [7:0]  CONT_MARK     = 8'h80;
    localparam logic [15:0] THREE_BYTE_MIN = 16'h0800;

endpackage

### sv/utf8_byte_stream_decoder_top.sv
// Top level of the UTF-8 byte stream decoder.
//
//  Channel   Handshake             Beat contents
//  -------   -------------------   ---------------------------
//  config    psel/penable/pready   paddr, pwdata, prdata
//  input     in_valid/in_ready     in_byte
//  output    out_valid/out_ready   code_point, status
//
// Each beat passes an input register and then a result register, which holds its result;
// one byte is taken every cycle while the output is not stalled.
// The sequence state registers are updated as a byte moves into the result register.
// A stalled output holds both registers; in_ready stays high while the input register can drain.
// Reset clears the sequence state and selects UTF-8 mode with a limit of 127.
module utf8_byte_stream_decoder_top
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  in_byte,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [15:0] code_point,
    output logic [1:0]  status
);
    import utf8d_pkg::*;

    cfg_t cfg;

    utf8d_regs u_regs
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    utf8d_core u_core
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .in_byte    (in_byte),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .code_point (code_point),
        .status     (status)
    );

endmodule

### sv/utf8d_regs.sv
// Configuration register file behind the APB-style port.
module utf8d_regs
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [2:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready,
    output utf8d_pkg::cfg_t     cfg
);
    import utf8d_pkg::*;

    logic       mode_reg;
    logic       mode_next;
    logic [7:0] limit_reg;
    logic [7:0] limit_next;
    logic       wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;

    always_comb
    begin
        mode_next  = mode_reg;
        limit_next = limit_reg;
        if (wr_en)
        begin
            case (paddr[2])
                REG_UTF8_MODE:         mode_next  = pwdata[0];
                REG_SINGLE_BYTE_LIMIT: limit_next = pwdata[7:0];
                default:               mode_next  = mode_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= UTF8_MODE_RESET;
            limit_reg <= BYTE_LIMIT_RESET;
        end
        else
        begin
            mode_reg  <= mode_next;
            limit_reg <= limit_next;
        end
    end

    always_comb
    begin
        case (paddr[2])
            REG_UTF8_MODE:         prdata = {31'd0, mode_reg};
            REG_SINGLE_BYTE_LIMIT: prdata = {24'd0, limit_reg};
            default:               prdata = 32'd0;
        endcase
    end

    assign cfg.utf8_mode         = mode_reg;
    assign cfg.single_byte_limit = limit_reg;

endmodule

### sv/utf8d_core.sv
// Decoder datapath: input register, sequence state, decode logic and result register.
module utf8d_core
(
    input  logic            clk,
    input  logic            rst_n,
    input  utf8d_pkg::cfg_t cfg,
    input  logic            in_valid,
    output logic            in_ready,
    input  logic [7:0]      in_byte,
    output logic            out_valid,
    input  logic            out_ready,
    output logic [15:0]     code_point,
    output logic [1:0]      status
);
    import utf8d_pkg::*;

    logic        hold_valid_reg;
    logic        hold_valid_next;
    logic [7:0]  hold_byte_reg;
    logic        out_valid_reg;
    logic        out_valid_next;
    logic [15:0] cp_reg;
    logic [15:0] cp_next;
    status_t     st_reg;
    status_t     st_next;
    logic [15:0] partial_reg;
    logic [15:0] partial_next;
    logic [1:0]  remain_reg;
    logic [1:0]  remain_next;

    logic        advance;
    logic        accept;
    logic [7:0]  b;
    logic [7:0]  cont;
    logic [15:0] merged;

    assign advance  = hold_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !hold_valid_reg || advance;
    assign accept   = in_valid && in_ready;

    assign b    = hold_byte_reg;
    assign cont = b ^ CONT_MARK;

    always_comb
    begin
        if (remain_reg == 2'd2)
        begin
            merged = partial_reg | {4'd0, cont[5:0], 6'd0};
        end
        else
        begin
            merged = partial_reg | {10'd0, cont[5:0]};
        end
    end

    always_comb
    begin
        cp_next      = 16'd0;
        st_next      = ST_PENDING;
        partial_next = 16'd0;
        remain_next  = 2'd0;
        if (!cfg.utf8_mode)
        begin
            if (b > cfg.single_byte_limit)
            begin
                st_next = ST_ILLEGAL;
            end
            else if (b == 8'd0)
            begin
                st_next = ST_END;
            end
            else
            begin
                st_next = ST_CHAR;
                cp_next = {8'd0, b};
            end
        end
        else if (remain_reg == 2'd0)
        begin
            if (b < ASCII_END)
            begin
                if (b == 8'd0)
                begin
                    st_next = ST_END;
                end
                else
                begin
                    st_next = ST_CHAR;
                    cp_next = {8'd0, b};
                end
            end
            else if (b < LEAD2_MIN || b >= LEAD_END)
            begin
                st_next = ST_ILLEGAL;
            end
            else if (b < LEAD3_MIN)
            begin
                partial_next = {5'd0, b[4:0], 6'd0};
                remain_next  = 2'd1;
            end
            else
            begin
                partial_next = {b[3:0], 12'd0};
                remain_next  = 2'd2;
            end
        end
        else if (cont[7:6] != 2'b00 || remain_reg == 2'd3)
        begin
            st_next = ST_ILLEGAL;
        end
        else if (remain_reg == 2'd1)
        begin
            st_next = ST_CHAR;
            cp_next = merged;
        end
        else if (merged < THREE_BYTE_MIN)
        begin
            st_next = ST_ILLEGAL;
        end
        else
        begin
            partial_next = merged;
            remain_next  = 2'd1;
        end
    end

    always_comb
    begin
        hold_valid_next = hold_valid_reg;
        if (accept)
        begin
            hold_valid_next = 1'b1;
        end
        else if (advance)
        begin
            hold_valid_next = 1'b0;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (advance)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
            partial_reg    <= 16'd0;
            remain_reg     <= 2'd0;
        end
        else
        begin
            hold_valid_reg <= hold_valid_next;
            out_valid_reg  <= out_valid_next;
            if (advance)
            begin
                partial_reg <= partial_next;
                remain_reg  <= remain_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            hold_byte_reg <= in_byte;
        end
        if (advance)
        begin
            cp_reg <= cp_next;
            st_reg <= st_next;
        end
    end

    assign out_valid  = out_valid_reg;
    assign code_point = cp_reg;
    assign status     = st_reg;

endmodule

### sv/utf8d_checker.sv
// Port-level checker for the decoder and its bind to the top level.
`include "utf8_byte_stream_decoder_top_macros.svh"

module utf8d_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [15:0] code_point,
    input logic [1:0]  status
);
    import utf8d_pkg::*;

    `UTF8D_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(code_point) && $stable(status), "stalled result beat changed")
    `UTF8D_ASSERT(a_no_char_zero, out_valid && status != ST_CHAR, code_point == 16'd0, "non-character beat carries a code point")
    `UTF8D_ASSERT(a_char_nonzero, out_valid && status == ST_CHAR, code_point != 16'd0, "character beat carries a zero code point")
    `UTF8D_ASSERT(a_ready_when_empty, !out_valid, in_ready, "input stalled while the result register is empty")

endmodule

bind utf8_byte_stream_decoder_top utf8d_checker u_checker (.*);

### verif/tb.sv
// Testbench for the UTF-8 byte stream decoder: directed table, random bursts, predictor check.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import utf8d_pkg::*;

    localparam int          ITEMS_PER_PHASE = 175;
    localparam int          PHASES          = 8;
    localparam int          CYCLE_LIMIT     = 300000;
    localparam logic [2:0]  ADDR_MODE       = {REG_UTF8_MODE, 2'b00};
    localparam logic [2:0]  ADDR_LIMIT      = {REG_SINGLE_BYTE_LIMIT, 2'b00};

    typedef enum logic {ROW_BYTE, ROW_CFG} row_kind_t;

    typedef struct packed {
        logic [15:0] cp;
        status_t     st;
    } decoded_t;

    typedef struct {
        row_kind_t   kind;
        logic [2:0]  addr;
        logic [7:0]  value;
        bit          typed;
        logic [15:0] cp;
        status_t     st;
    } stim_row_t;

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        psel      = 1'b0;
    logic        penable   = 1'b0;
    logic        pwrite    = 1'b0;
    logic [2:0]  paddr     = '0;
    logic [31:0] pwdata    = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        in_valid  = 1'b0;
    logic        in_ready;
    logic [7:0]  in_byte   = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [15:0] code_point;
    logic [1:0]  status;

    logic        mode_utf8;
    logic [7:0]  byte_limit;
    logic [15:0] seq_value;
    logic [1:0]  seq_left;

    decoded_t    decoded_q[$];
    int          mismatches  = 0;
    int          cycle_count = 0;
    bit          calm        = 1'b0;

    stim_row_t directed_rows[] = '{
        '{ROW_BYTE, ADDR_MODE,  8'h00, 1'b1, 16'h0000, ST_END},
        '{ROW_BYTE, ADDR_MODE,  8'h7F, 1'b1, 16'h007F, ST_CHAR},
        '{ROW_BYTE, ADDR_MODE,  8'h80, 1'b1, 16'h0000, ST_ILLEGAL},
        '{ROW_BYTE, ADDR_MODE,  8'hC1, 1'b1, 16'h0000, ST_ILLEGAL},
        '{ROW_BYTE, ADDR_MODE,  8'hF0, 1'b1, 16'h0000, ST_ILLEGAL},
        '{ROW_BYTE, ADDR_MODE,  8'hFF, 1'b1, 16'h0000, ST_ILLEGAL},
        '{ROW_BYTE, ADDR_MODE,  8'hC2, 1'b0, 16'h0000, ST_PENDING},
        '{ROW_BYTE, ADDR_MODE,  8'h80, 1'b0, 16'h0000, ST_PENDING},
        '{ROW_BYTE, ADDR_MODE,  8'hDF, 1'b0, 16'h0000, ST_PENDING},
        '{ROW_BYTE, ADDR_MODE,  8'hBF, 1'b0, 16'h0000, ST_PENDING},
        '{ROW_BYTE, ADDR_MODE,  8'hE0, 1'b0, 16'h0000, ST_PENDING},
        '{ROW_BYTE, ADDR_MODE,  8'hA0, 1'b0, 16'h0000, ST_PENDING},
        '{ROW_BYTE, ADDR_MODE,  8'h80, 1'b0, 16'h0000, ST_PENDING},
        '{ROW_BYTE, ADDR_MODE,  8'hEF, 1'b0, 16'h0000, ST_PENDING},
        '{ROW_BYTE, ADDR_MODE,  8'hBF, 1'b0, 16'h0000, ST_PENDING},
        '{ROW_BYTE, ADDR_MODE,  8'hBF, 1'b0, 16'h0000, ST_PENDING},
        '{ROW_BYTE, ADDR_MODE,  8'hE0, 1'b0, 16'h0000, ST_PENDING},
        '{ROW_BYTE, ADDR_MODE,  8'h9F, 1'b0, 16'h0000, ST_PENDING},
        '{ROW_BYTE, ADDR_MODE,  8'hED, 1'b0, 16'h0000, ST_PENDING},
        '{ROW_BYTE, ADDR_MODE,  8'hA0, 1'b0, 16'h0000, ST_PENDING},
        '{ROW_BYTE, ADDR_MODE,  8'h80, 1'b0, 16'h0000, ST_PENDING},
        '{ROW_BYTE, ADDR_MODE,  8'hC3, 1'b0, 16'h0000, ST_PENDING},
        '{ROW_BYTE, ADDR_MODE,  8'h00, 1'b0, 16'h0000, ST_PENDING},
        '{ROW_BYTE, ADDR_MODE,  8'hE1, 1'b0, 16'h0000, ST_PENDING},
        '{ROW_BYTE, ADDR_MODE,  8'h41, 1'b0, 16'h0000, ST_PENDING},
        '{ROW_BYTE, ADDR_MODE,  8'hE4, 1'b0, 16'h0000, ST_PENDING},
        '{ROW_CFG,  ADDR_LIMIT, 8'd200, 1'b0, 16'h0000, ST_PENDING},
        '{ROW_BYTE, ADDR_MODE,  8'h80, 1'b0, 16'h0000, ST_PENDING},
        '{ROW_CFG,  ADDR_MODE,  8'h00, 1'b0, 16'h0000, ST_PENDING},
        '{ROW_BYTE, ADDR_MODE,  8'h85, 1'b1, 16'h0085, ST_CHAR},
        '{ROW_BYTE, ADDR_MODE,  8'hD0, 1'b1, 16'h0000, ST_ILLEGAL},
        '{ROW_BYTE, ADDR_MODE,  8'h00, 1'b1, 16'h0000, ST_END},
        '{ROW_CFG,  ADDR_MODE,  8'h01, 1'b0, 16'h0000, ST_PENDING},
        '{ROW_BYTE, ADDR_MODE,  8'h9A, 1'b1, 16'h0000, ST_ILLEGAL}
    };

    logic [7:0] mode_plan[PHASES]  = '{8'd1, 8'd0, 8'd1, 8'd0, 8'd1, 8'd0, 8'd0, 8'd1};
    logic [7:0] limit_plan[PHASES] = '{8'd127, 8'd0, 8'd255, 8'd255, 8'd0, 8'd127, 8'd100, 8'd128};

    utf8_byte_stream_decoder_top DUT
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .in_byte    (in_byte),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .code_point (code_point),
        .status     (status)
    );

    always #6 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        out_ready <= calm || ($urandom_range(99) >= 22);
    end

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("MISMATCH at cycle %0d: %s got %0h expected %0h", cycle_count, what, got, want);
        mismatches++;
    endtask

    always @(posedge clk)
    begin
        decoded_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (decoded_q.size() == 0)
            begin
                report_mismatch("unexpected beat, status", {30'd0, status}, 32'd0);
            end
            else
            begin
                want = decoded_q.pop_front();
                if (code_point !== want.cp)
                    report_mismatch("code_point", {16'd0, code_point}, {16'd0, want.cp});
                if (status !== want.st)
                    report_mismatch("status", {30'd0, status}, {30'd0, want.st});
            end
        end
    end

    function automatic void decode_byte(input logic [7:0] b, output logic [15:0] cp,
                                        output status_t st);
        logic [7:0] cont;
        cp = 16'h0000;
        st = ST_PENDING;
        if (!mode_utf8)
        begin
            seq_value = '0;
            seq_left  = '0;
            if (b > byte_limit)
                st = ST_ILLEGAL;
            else if (b == 8'h00)
                st = ST_END;
            else
            begin
                st = ST_CHAR;
                cp = {8'h00, b};
            end
        end
        else if (seq_left == 2'd0)
        begin
            if (b < ASCII_END)
            begin
                if (b == 8'h00)
                    st = ST_END;
                else
                begin
                    st = ST_CHAR;
                    cp = {8'h00, b};
                end
            end
            else if (b < LEAD2_MIN || b >= LEAD_END)
                st = ST_ILLEGAL;
            else if (b < LEAD3_MIN)
            begin
                seq_value = {5'd0, b[4:0], 6'd0};
                seq_left  = 2'd1;
            end
            else
            begin
                seq_value = {b[3:0], 12'd0};
                seq_left  = 2'd2;
            end
        end
        else
        begin
            cont = b ^ CONT_MARK;
            if (cont >= 8'h40)
            begin
                seq_value = '0;
                seq_left  = '0;
                st = ST_ILLEGAL;
            end
            else
            begin
                seq_left  = seq_left - 2'd1;
                seq_value = seq_value | (16'(cont[5:0]) << (6 * seq_left));
                if (seq_left == 2'd0)
                begin
                    cp = seq_value;
                    st = ST_CHAR;
                    seq_value = '0;
                end
                else if (seq_value < THREE_BYTE_MIN)
                begin
                    seq_value = '0;
                    seq_left  = '0;
                    st = ST_ILLEGAL;
                end
            end
        end
    endfunction

    task automatic send_byte(input logic [7:0] b, input bit typed, input logic [15:0] want_cp,
                             input status_t want_st);
        logic [15:0] cp;
        status_t     st;
        decoded_t    exp;
        if (!calm && $urandom_range(99) < 11)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_byte  <= b;
        do @(posedge clk); while (in_ready !== 1'b1);
        decode_byte(b, cp, st);
        exp.cp = typed ? want_cp : cp;
        exp.st = typed ? want_st : st;
        decoded_q.push_back(exp);
    endtask

    task automatic drain_results();
        in_valid <= 1'b0;
        while (decoded_q.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input logic [2:0] addr, input logic [7:0] value);
        logic [31:0] got;
        logic [31:0] want;
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= addr;
        pwdata  <= {24'd0, value};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        if (addr == ADDR_MODE)
            mode_utf8 = value[0];
        else
            byte_limit = value;
        pwrite  <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        got  = (addr == ADDR_MODE) ? {31'd0, prdata[0]} : {24'd0, prdata[7:0]};
        want = (addr == ADDR_MODE) ? {31'd0, mode_utf8} : {24'd0, byte_limit};
        if (got !== want)
            report_mismatch("register readback", got, want);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    initial
    begin : stimulus
        logic [7:0] burst[$];
        logic [7:0] lead;
        logic [7:0] lim;
        int         sent;
        int         pick;
        mode_utf8  = UTF8_MODE_RESET;
        byte_limit = BYTE_LIMIT_RESET;
        seq_value  = '0;
        seq_left   = '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i])
        begin
            if (directed_rows[i].kind == ROW_CFG)
            begin
                drain_results();
                write_reg(directed_rows[i].addr, directed_rows[i].value);
            end
            else
            begin
                send_byte(directed_rows[i].value, directed_rows[i].typed,
                          directed_rows[i].cp, directed_rows[i].st);
            end
        end

        for (int p = 0; p < PHASES; p++)
        begin
            drain_results();
            lim = limit_plan[p];
            if (p[0])
            begin
                write_reg(ADDR_LIMIT, lim);
                write_reg(ADDR_MODE, mode_plan[p]);
            end
            else
            begin
                write_reg(ADDR_MODE, mode_plan[p]);
                write_reg(ADDR_LIMIT, lim);
            end
            calm = (p == 3);
            sent = 0;
            while (sent < ITEMS_PER_PHASE)
            begin
                burst.delete();
                pick = $urandom_range(99);
                if (mode_plan[p] == 8'd0)
                begin
                    if (pick < 15)
                        burst.push_back(lim);
                    else if (pick < 30)
                        burst.push_back(lim + 8'd1);
                    else if (pick < 36)
                        burst.push_back(8'h00);
                    else
                        burst.push_back(8'($urandom_range(255)));
                end
                else if (pick < 25)
                    burst.push_back(8'($urandom_range(1, 127)));
                else if (pick < 30)
                    burst.push_back(8'h00);
                else if (pick < 55)
                begin
                    burst.push_back(8'($urandom_range(8'hC2, 8'hDF)));
                    burst.push_back(8'($urandom_range(8'h80, 8'hBF)));
                end
                else if (pick < 80)
                begin
                    lead = 8'($urandom_range(8'hE0, 8'hEF));
                    burst.push_back(lead);
                    if (lead == LEAD3_MIN)
                        burst.push_back(8'($urandom_range(8'hA0, 8'hBF)));
                    else
                        burst.push_back(8'($urandom_range(8'h80, 8'hBF)));
                    burst.push_back(8'($urandom_range(8'h80, 8'hBF)));
                end
                else if (pick < 90)
                begin
                    burst.push_back(8'($urandom_range(8'hC2, 8'hEF)));
                    burst.push_back(8'($urandom_range(255)));
                    if ($urandom_range(1))
                        burst.push_back(8'($urandom_range(255)));
                end
                else
                    burst.push_back(8'($urandom_range(255)));
                foreach (burst[i])
                    send_byte(burst[i], 1'b0, 16'h0000, ST_PENDING);
                sent += burst.size();
            end
            calm = 1'b0;
        end

        drain_results();
        repeat (8) @(posedge clk);
        if (mismatches == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end
endmodule

### filelist.f
+incdir+sv
sv/utf8d_pkg.sv
sv/utf8d_regs.sv
sv/utf8d_core.sv
sv/utf8_byte_stream_decoder_top.sv
sv/utf8d_checker.sv
verif/tb.sv
